FILE: rtl/atsds_pkg.sv
// Shared types and codes for the value table search, delete and sort unit.
`default_nettype none

package atsds_pkg;

	// Fixed widths of the transaction fields.
	localparam int DATA_W  = 32;
	localparam int FIELD_W = 6;
	localparam int CMD_W   = 3;

	// Command codes; codes without a member are treated as no-operation.
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR   = 3'd0,
		CMD_APPEND  = 3'd1,
		CMD_SEARCH  = 3'd2,
		CMD_DELETE  = 3'd3,
		CMD_SORT    = 3'd4,
		CMD_DISPLAY = 3'd5
	} cmd_e;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SORT_WB,
		ST_FINISH
	} state_e;

	// Input transaction.
	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] operand_value;
	} req_t;

	// Result transaction.
	typedef struct packed {
		logic signed [DATA_W-1:0] entry_value;
		logic [FIELD_W-1:0]       position;
		logic [FIELD_W-1:0]       entry_count;
		logic                     hit;
		logic                     full_error;
		logic                     last;
	} rsp_t;

endpackage

`default_nettype wire

FILE: rtl/atsds_ram.sv
// Table storage: one write port and one read port with registered read data.
`default_nettype none

module atsds_ram
	import atsds_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            we,
	input  wire logic [$clog2(DEPTH)-1:0]        waddr,
	input  wire logic signed [DATA_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0]        raddr,
	output      logic signed [DATA_W-1:0]        rd_data
);

	logic signed [DATA_W-1:0] mem_q [DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_data <= mem_q[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/array_table_search_delete_sort_unit.sv
// Top level of the value table unit: command sequencer, compare unit and table storage.
//
// Usage: drive request and pulse start while busy is low; the transaction is
// taken at that clock edge. Results come out on result, each valid for exactly
// one cycle while done is high; result.last marks the final result of a command.
// The receiver cannot stall the block, so every result must be taken when shown.
//
// Clear, append and unused codes do not raise busy: their single result appears
// on the cycle after start, and a new command may be issued right away.
// Search, delete and display with n stored entries stream the table through the
// single read port, one entry a cycle, while holding busy; the results of a search
// or display come out while the walk proceeds, and the last one is shown in the
// first cycle that busy is low.
// Sort is a selection sort on a signed comparison: pass i reads entries i..n-1
// through the single memory read port and writes back the minimum to slot i.
// Reset empties the table (fill count zero) and returns the sequencer to idle;
// the table memory itself is not cleared, since slots beyond the count are
// never read.
`default_nettype none

module array_table_search_delete_sort_unit
	import atsds_pkg::*;
#(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire req_t request,
	output      logic busy,
	output      logic done,
	output      rsp_t result
);

	localparam int IdxW = $clog2(TABLE_DEPTH);
	localparam int CntW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CntW-1:0] DepthC = CntW'(TABLE_DEPTH);
	localparam logic [CntW-1:0] TwoC   = CntW'(2);

	// Control registers.
	state_e             state_q, state_d;
	logic [CntW-1:0]    count_q, count_d;
	logic               iss_q, iss_d;
	logic               rd_vld_s1, rd_vld_d;
	logic               pend_vld_q, pend_vld_d;
	logic               done_q, emit;

	// Datapath registers.
	cmd_e                     cmd_q, cmd_d;
	logic signed [DATA_W-1:0] val_q, val_d;
	logic [CntW-1:0]          rd_addr_q, rd_addr_d;
	logic [IdxW-1:0]          rd_idx_s1, rd_idx_d;
	logic [CntW-1:0]          wr_ptr_q, wr_ptr_d;
	logic                     removed_q, removed_d;
	logic signed [DATA_W-1:0] pend_val_q, pend_val_d;
	logic [FIELD_W-1:0]       pend_pos_q, pend_pos_d;
	logic signed [DATA_W-1:0] cur_q, cur_d;
	logic [CntW-1:0]          sort_i_q, sort_i_d;
	rsp_t                     result_q, emit_res;

	// Memory port signals.
	logic                     mem_we;
	logic [IdxW-1:0]          mem_waddr;
	logic signed [DATA_W-1:0] mem_wdata;
	logic [IdxW-1:0]          mem_raddr;
	logic signed [DATA_W-1:0] rd_data;

	// Helper values.
	logic [CntW-1:0] rd_next;
	logic [CntW-1:0] rd_pos;
	logic [CntW-1:0] cnt_next;
	logic [CntW-1:0] sort_lim;
	logic            match;

	assign rd_next  = rd_addr_q + 1'b1;
	assign rd_pos   = CntW'(rd_idx_s1) + 1'b1;
	assign cnt_next = count_q + 1'b1;
	assign sort_lim = sort_i_q + TwoC;
	assign match    = (cmd_q == CMD_DISPLAY) || (rd_data == val_q);

	atsds_ram #(
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.raddr  (mem_raddr),
		.rd_data(rd_data)
	);

	// Sequencer: next state, memory accesses and result selection.
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		iss_d      = iss_q;
		rd_vld_d   = 1'b0;
		pend_vld_d = pend_vld_q;
		cmd_d      = cmd_q;
		val_d      = val_q;
		rd_addr_d  = rd_addr_q;
		rd_idx_d   = rd_idx_s1;
		wr_ptr_d   = wr_ptr_q;
		removed_d  = removed_q;
		pend_val_d = pend_val_q;
		pend_pos_d = pend_pos_q;
		cur_d      = cur_q;
		sort_i_d   = sort_i_q;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		mem_raddr  = rd_addr_q[IdxW-1:0];
		emit       = 1'b0;
		emit_res   = '0;
		emit_res.entry_count = FIELD_W'(count_q);

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					emit_res.last = 1'b1;
					unique case (cmd_e'(request.command))
						CMD_CLEAR: begin
							count_d = '0;
							emit = 1'b1;
							emit_res.entry_count = '0;
						end
						CMD_APPEND: begin
							emit = 1'b1;
							if (count_q >= DepthC) begin
								emit_res.full_error = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[IdxW-1:0];
								mem_wdata = request.operand_value;
								count_d   = cnt_next;
								emit_res.entry_value = request.operand_value;
								emit_res.position    = FIELD_W'(cnt_next);
								emit_res.entry_count = FIELD_W'(cnt_next);
								emit_res.hit         = 1'b1;
							end
						end
						CMD_SEARCH, CMD_DELETE, CMD_DISPLAY: begin
							cmd_d      = cmd_e'(request.command);
							val_d      = request.operand_value;
							rd_addr_d  = '0;
							iss_d      = (count_q != '0);
							wr_ptr_d   = '0;
							removed_d  = 1'b0;
							pend_vld_d = 1'b0;
							state_d    = ST_SCAN;
						end
						CMD_SORT: begin
							cmd_d      = CMD_SORT;
							rd_addr_d  = '0;
							sort_i_d   = '0;
							iss_d      = (count_q >= TwoC);
							pend_vld_d = 1'b0;
							state_d    = ST_SCAN;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end

			ST_SCAN: begin
				// Issue one read a cycle until the end of the table.
				if (iss_q) begin
					rd_vld_d  = 1'b1;
					rd_idx_d  = rd_addr_q[IdxW-1:0];
					rd_addr_d = rd_next;
					iss_d     = (rd_next < count_q);
				end
				// Handle the entry read in the previous cycle.
				if (rd_vld_s1) begin
					unique case (cmd_q)
						CMD_DELETE: begin
							if (rd_data == val_q) begin
								removed_d = 1'b1;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = wr_ptr_q[IdxW-1:0];
								mem_wdata = rd_data;
								wr_ptr_d  = wr_ptr_q + 1'b1;
							end
						end
						CMD_SORT: begin
							if (CntW'(rd_idx_s1) == sort_i_q) begin
								cur_d = rd_data;
							end else if (cur_q > rd_data) begin
								mem_we    = 1'b1;
								mem_waddr = rd_idx_s1;
								mem_wdata = cur_q;
								cur_d     = rd_data;
							end
						end
						default: begin
							// Search and display: hold back one hit so the final
							// one can carry the last flag.
							if (match) begin
								if (pend_vld_q) begin
									emit = 1'b1;
									emit_res.entry_value = pend_val_q;
									emit_res.position    = pend_pos_q;
									emit_res.hit         = 1'b1;
								end
								pend_vld_d = 1'b1;
								pend_val_d = rd_data;
								pend_pos_d = FIELD_W'(rd_pos);
							end
						end
					endcase
				end
				// End of the pass once all reads are handled.
				if (!iss_q && !rd_vld_s1) begin
					priority if (cmd_q == CMD_DELETE) begin
						count_d = wr_ptr_q;
						state_d = ST_FINISH;
					end else if (cmd_q == CMD_SORT && count_q >= TwoC) begin
						state_d = ST_SORT_WB;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end

			ST_SORT_WB: begin
				// Store the pass minimum and start the next pass, if one remains.
				mem_we    = 1'b1;
				mem_waddr = sort_i_q[IdxW-1:0];
				mem_wdata = cur_q;
				sort_i_d  = sort_i_q + 1'b1;
				if (sort_lim < count_q) begin
					rd_addr_d = sort_i_q + 1'b1;
					iss_d     = 1'b1;
					state_d   = ST_SCAN;
				end else begin
					state_d = ST_FINISH;
				end
			end

			ST_FINISH: begin
				emit = 1'b1;
				emit_res.last = 1'b1;
				if (cmd_q == CMD_DELETE) begin
					emit_res.hit = removed_q;
				end else if (cmd_q != CMD_SORT && pend_vld_q) begin
					emit_res.entry_value = pend_val_q;
					emit_res.position    = pend_pos_q;
					emit_res.hit         = 1'b1;
				end
				state_d = ST_IDLE;
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			iss_q      <= 1'b0;
			rd_vld_s1  <= 1'b0;
			pend_vld_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			iss_q      <= iss_d;
			rd_vld_s1  <= rd_vld_d;
			pend_vld_q <= pend_vld_d;
			done_q     <= emit;
		end
	end

	// Datapath state.
	always_ff @(posedge clk) begin
		cmd_q      <= cmd_d;
		val_q      <= val_d;
		rd_addr_q  <= rd_addr_d;
		rd_idx_s1  <= rd_idx_d;
		wr_ptr_q   <= wr_ptr_d;
		removed_q  <= removed_d;
		pend_val_q <= pend_val_d;
		pend_pos_q <= pend_pos_d;
		cur_q      <= cur_d;
		sort_i_q   <= sort_i_d;
		result_q   <= emit_res;
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// The fill count never passes the table depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DepthC)
		else $error("fill count beyond table depth");

	// A result that is not the final one only comes out during a table walk.
	assert property (@(posedge clk) disable iff (!arst_n) (done && !result.last) |-> busy)
		else $error("non-final result outside a walk");

	// A refused append never reports a hit.
	assert property (@(posedge clk) disable iff (!arst_n) (done && result.full_error) |-> !result.hit)
		else $error("full error together with hit");

	// Compaction writes never run ahead of the entry being read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && cmd_q == CMD_DELETE && rd_vld_s1) |-> wr_ptr_q <= CntW'(rd_idx_s1))
		else $error("delete write pointer ahead of read index");

	// A walk command raises busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (request.command == CMD_SEARCH || request.command == CMD_DELETE
			|| request.command == CMD_SORT || request.command == CMD_DISPLAY)) |=> busy)
		else $error("walk command did not raise busy");

endmodule

`default_nettype wire
